>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the haversine distance RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle, off during reset
`define HDU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle, checked through reset
`define HDU_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hdu_pkg.sv
// ---------------------------------------------------------------------------
// hdu_pkg
// Widths, constants and elaboration-time table functions for the haversine
// distance unit.
// ---------------------------------------------------------------------------
package hdu_pkg;

   localparam int ANGLE_FRAC_BITS   = 30;
   localparam int CORDIC_STAGES_DEF = 32;

   localparam int LAT_W    = 24;
   localparam int LON_W    = 25;
   localparam int DIST_W   = 26;
   localparam int RADIUS_W = 24;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

   // angles in units of 2^-17 degree
   localparam int UNIT_W = 26;
   localparam int TURN_W = 27;
   localparam int MAG_W  = 24;
   localparam logic signed [TURN_W-1:0] FULL_TURN    = 27'sd47185920;
   localparam logic signed [TURN_W-1:0] HALF_TURN    = 27'sd23592960;
   localparam logic signed [TURN_W-1:0] QUARTER_TURN = 27'sd11796480;

   localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
   localparam int D2R_W    = 39;
   localparam int D2R_LO_W = 20;
   localparam int D2R_HI_W = D2R_W - D2R_LO_W;
   localparam logic [63:0] D2R_FULL = (PI60 / 64'd180 + 64'd32768) >> 16;
   localparam logic [D2R_W-1:0] DEG2RAD = D2R_FULL[D2R_W-1:0];
   localparam int Z_SHIFT = 61 - ANGLE_FRAC_BITS;

   localparam int ANG_W   = ANGLE_FRAC_BITS + 3;
   localparam int TRIG_W  = 32;
   localparam int AMP_W   = 33;
   localparam int A32_W   = 33;
   localparam logic [A32_W-1:0] A32_ONE = 33'h1_0000_0000;
   localparam int SQ_W     = 64;
   localparam int SQ_STEPS = 32;
   localparam int ROOT_W   = 32;
   localparam int VEC_W    = 36;
   localparam int CENT_W   = 32;
   localparam int PROD_W   = RADIUS_W + CENT_W + 1;

   // restoring long division, elaboration only
   function automatic logic [63:0] udiv_const(input logic [63:0] num,
                                              input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      int n;
      quo = '0;
      rem = '0;
      for (n = 63; n >= 0; n--) begin
         rem = {rem[62:0], num[n]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[n] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] isqrt_const(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] pbit;
      int k;
      rem  = v;
      root = '0;
      pbit = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
         if (rem >= root + pbit) begin
            rem  = rem - (root + pbit);
            root = (root >> 1) + pbit;
         end else begin
            root = root >> 1;
         end
         pbit = pbit >> 2;
      end
      return root;
   endfunction

   // atan(2^-i) rounded to the angle format
   function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
      logic [63:0] acc;
      logic [63:0] term;
      int k;
      acc = '0;
      if (i == 0) begin
         acc = (PI60 + 64'd2) >> 2;
      end else begin
         for (k = 0; k < 31; k++) begin
            if (i * (2 * k + 1) <= 60) begin
               term = udiv_const(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
               if ((k & 1) != 0) begin
                  acc = acc - term;
               end else begin
                  acc = acc + term;
               end
            end
         end
      end
      acc = (acc + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
      return acc[ANG_W-1:0];
   endfunction

   // inverse cordic gain for a given stage count
   function automatic logic signed [ANG_W-1:0] gain_entry(input int stages);
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] r;
      logic [63:0] q;
      int i;
      int n;
      p = 64'd1 << 60;
      for (i = 0; i < 64; i++) begin
         if (i < stages && 2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      s = isqrt_const(p);
      r = '0;
      q = '0;
      for (n = 0; n < ANGLE_FRAC_BITS + 31; n++) begin
         r = (r << 1) | ((n == 0) ? 64'd1 : 64'd0);
         q = q << 1;
         if (r >= s) begin
            r    = r - s;
            q[0] = 1'b1;
         end
      end
      return q[ANG_W-1:0];
   endfunction

   // shift right by n with rounding half away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int n);
      logic [63:0] mag;
      if (n == 0) begin
         return v;
      end
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (n - 1))) >> n;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [63:0] to_q30(input logic signed [63:0] v);
      if (ANGLE_FRAC_BITS >= 30) begin
         return round_shift(v, ANGLE_FRAC_BITS - 30);
      end
      return v <<< (30 - ANGLE_FRAC_BITS);
   endfunction

endpackage

>>> rtl/hdu_req_if.sv
// ---------------------------------------------------------------------------
// hdu_req_if
// Point-pair request channel: valid/ready plus two coordinate pairs.
// ---------------------------------------------------------------------------
interface hdu_req_if;
   import hdu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] first_latitude;
   logic signed [LON_W-1:0] first_longitude;
   logic signed [LAT_W-1:0] second_latitude;
   logic signed [LON_W-1:0] second_longitude;

   modport source (output valid, first_latitude, first_longitude,
                   second_latitude, second_longitude, input ready);
   modport sink   (input valid, first_latitude, first_longitude,
                   second_latitude, second_longitude, output ready);
endinterface

>>> rtl/hdu_rsp_if.sv
// ---------------------------------------------------------------------------
// hdu_rsp_if
// Distance response channel: valid/ready plus distance in metres.
// ---------------------------------------------------------------------------
interface hdu_rsp_if;
   import hdu_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_m;

   modport source (output valid, distance_m, input ready);
   modport sink   (input valid, distance_m, output ready);
endinterface

>>> rtl/hdu_sincos.sv
// ---------------------------------------------------------------------------
// hdu_sincos
// One angle lane: range reduction, degree to radian scaling and a pipelined
// rotation cordic, giving sine or cosine in Q30.
// ---------------------------------------------------------------------------
module hdu_sincos #(
   parameter int unsigned STAGES = hdu_pkg::CORDIC_STAGES_DEF,
   parameter bit          COSINE = 1'b0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [hdu_pkg::UNIT_W-1:0] angle_units,
   output logic                             out_valid,
   output logic signed [hdu_pkg::TRIG_W-1:0] trig_q30
);
   import hdu_pkg::*;

   localparam int PLO_W = MAG_W + D2R_LO_W;
   localparam int PHI_W = MAG_W + D2R_HI_W;
   localparam logic signed [ANG_W-1:0] GAIN = gain_entry(STAGES);

   logic signed [TURN_W-1:0] u_ext;
   logic signed [TURN_W-1:0] wrapped;
   logic signed [TURN_W-1:0] folded;
   logic                     fold;
   logic [MAG_W-1:0]         mag_in;

   logic [MAG_W-1:0] mag_ff;
   logic             neg1_ff, flip1_ff, v1_ff;
   logic [PLO_W-1:0] plo_ff;
   logic [PHI_W-1:0] phi_ff;
   logic             neg2_ff, flip2_ff, v2_ff;
   logic signed [ANG_W-1:0] z3_ff;
   logic             flip3_ff, v3_ff;

   logic [63:0]             prod;
   logic [63:0]             zmag;
   logic signed [ANG_W-1:0] z3_in;

   logic signed [ANG_W-1:0] rot_x_ff [1:STAGES];
   logic signed [ANG_W-1:0] rot_y_ff [1:STAGES];
   logic signed [ANG_W-1:0] rot_z_ff [1:STAGES];
   logic                    rot_f_ff [1:STAGES];
   logic                    rot_v_ff [1:STAGES];

   logic signed [63:0]       q_x;
   logic signed [63:0]       q_y;
   logic signed [TRIG_W-1:0] trig_in;
   logic signed [TRIG_W-1:0] trig_ff;
   logic                     out_valid_ff;

   // fold into [-180,180) then into [-90,90], cosine negates on reflection
   always_comb begin
      u_ext = TURN_W'(angle_units);
      if (u_ext >= HALF_TURN) begin
         wrapped = u_ext - FULL_TURN;
      end else if (u_ext < -HALF_TURN) begin
         wrapped = u_ext + FULL_TURN;
      end else begin
         wrapped = u_ext;
      end
      fold   = 1'b0;
      folded = wrapped;
      if (wrapped > QUARTER_TURN) begin
         folded = HALF_TURN - wrapped;
         fold   = 1'b1;
      end else if (wrapped < -QUARTER_TURN) begin
         folded = -HALF_TURN - wrapped;
         fold   = 1'b1;
      end
      mag_in = MAG_W'(folded[TURN_W-1] ? -folded : folded);
   end

   always_comb begin
      prod  = (64'(phi_ff) << D2R_LO_W) + 64'(plo_ff);
      zmag  = (prod + (64'd1 << (Z_SHIFT - 1))) >> Z_SHIFT;
      z3_in = neg2_ff ? -ANG_W'(zmag) : ANG_W'(zmag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         neg1_ff  <= folded[TURN_W-1];
         flip1_ff <= fold;
         plo_ff   <= PLO_W'(mag_ff) * PLO_W'(DEG2RAD[D2R_LO_W-1:0]);
         phi_ff   <= PHI_W'(mag_ff) * PHI_W'(DEG2RAD[D2R_W-1:D2R_LO_W]);
         neg2_ff  <= neg1_ff;
         flip2_ff <= flip1_ff;
         z3_ff    <= z3_in;
         flip3_ff <= flip2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [ANG_W-1:0] ATAN_I = atan_entry(i);
      logic signed [ANG_W-1:0] x_cur, y_cur, z_cur;
      logic                    f_cur, v_cur;

      if (i == 0) begin : g_first
         assign x_cur = GAIN;
         assign y_cur = '0;
         assign z_cur = z3_ff;
         assign f_cur = flip3_ff;
         assign v_cur = v3_ff;
      end else begin : g_next
         assign x_cur = rot_x_ff[i];
         assign y_cur = rot_y_ff[i];
         assign z_cur = rot_z_ff[i];
         assign f_cur = rot_f_ff[i];
         assign v_cur = rot_v_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_cur[ANG_W-1]) begin
               rot_x_ff[i+1] <= x_cur - (y_cur >>> i);
               rot_y_ff[i+1] <= y_cur + (x_cur >>> i);
               rot_z_ff[i+1] <= z_cur - ATAN_I;
            end else begin
               rot_x_ff[i+1] <= x_cur + (y_cur >>> i);
               rot_y_ff[i+1] <= y_cur - (x_cur >>> i);
               rot_z_ff[i+1] <= z_cur + ATAN_I;
            end
            rot_f_ff[i+1] <= f_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rot_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            rot_v_ff[i+1] <= v_cur;
         end
      end
   end

   always_comb begin
      q_x = to_q30(64'(rot_x_ff[STAGES]));
      q_y = to_q30(64'(rot_y_ff[STAGES]));
      if (COSINE) begin
         trig_in = rot_f_ff[STAGES] ? -TRIG_W'(q_x) : TRIG_W'(q_x);
      end else begin
         trig_in = TRIG_W'(q_y);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= rot_v_ff[STAGES];
      end
   end

   assign out_valid = out_valid_ff;
   assign trig_q30  = trig_ff;
endmodule

>>> rtl/hdu_isqrt.sv
// ---------------------------------------------------------------------------
// hdu_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module hdu_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [hdu_pkg::SQ_W-1:0]      radicand,
   output logic                          out_valid,
   output logic [hdu_pkg::ROOT_W-1:0]    root
);
   import hdu_pkg::*;

   logic [SQ_W-1:0] rem_ff  [1:SQ_STEPS];
   logic [SQ_W-1:0] root_ff [1:SQ_STEPS];
   logic            v_ff    [1:SQ_STEPS];

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
      localparam logic [SQ_W-1:0] PBIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
      logic [SQ_W-1:0] rem_cur, root_cur, trial;
      logic            v_cur;

      if (i == 0) begin : g_first
         assign rem_cur  = radicand;
         assign root_cur = '0;
         assign v_cur    = in_valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[i];
         assign root_cur = root_ff[i];
         assign v_cur    = v_ff[i];
      end

      assign trial = root_cur + PBIT;

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_cur >= trial) begin
               rem_ff[i+1]  <= rem_cur - trial;
               root_ff[i+1] <= (root_cur >> 1) + PBIT;
            end else begin
               rem_ff[i+1]  <= rem_cur;
               root_ff[i+1] <= root_cur >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_cur;
         end
      end
   end

   assign out_valid = v_ff[SQ_STEPS];
   assign root      = root_ff[SQ_STEPS][ROOT_W-1:0];
endmodule

>>> rtl/hdu_cordic_vec.sv
// ---------------------------------------------------------------------------
// hdu_cordic_vec
// Pipelined vectoring cordic: angle of (x, y) for non-negative x and y.
// ---------------------------------------------------------------------------
module hdu_cordic_vec #(
   parameter int unsigned STAGES = hdu_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [hdu_pkg::ROOT_W-1:0]        x_root,
   input  logic [hdu_pkg::ROOT_W-1:0]        y_root,
   output logic                              out_valid,
   output logic signed [hdu_pkg::ANG_W-1:0]  angle
);
   import hdu_pkg::*;

   logic signed [VEC_W-1:0] vx_ff [1:STAGES];
   logic signed [VEC_W-1:0] vy_ff [1:STAGES];
   logic signed [ANG_W-1:0] vz_ff [1:STAGES];
   logic                    vv_ff [1:STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_vec
      localparam logic signed [ANG_W-1:0] ATAN_I = atan_entry(i);
      logic signed [VEC_W-1:0] x_cur, y_cur;
      logic signed [ANG_W-1:0] z_cur;
      logic                    v_cur;

      if (i == 0) begin : g_first
         assign x_cur = $signed(VEC_W'(x_root));
         assign y_cur = $signed(VEC_W'(y_root));
         assign z_cur = '0;
         assign v_cur = in_valid;
      end else begin : g_next
         assign x_cur = vx_ff[i];
         assign y_cur = vy_ff[i];
         assign z_cur = vz_ff[i];
         assign v_cur = vv_ff[i];
      end

      // drive y toward zero, accumulating the angle turned
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_cur[VEC_W-1]) begin
               vx_ff[i+1] <= x_cur + (y_cur >>> i);
               vy_ff[i+1] <= y_cur - (x_cur >>> i);
               vz_ff[i+1] <= z_cur + ATAN_I;
            end else begin
               vx_ff[i+1] <= x_cur - (y_cur >>> i);
               vy_ff[i+1] <= y_cur + (x_cur >>> i);
               vz_ff[i+1] <= z_cur - ATAN_I;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[i+1] <= 1'b0;
         end else if (en) begin
            vv_ff[i+1] <= v_cur;
         end
      end
   end

   assign out_valid = vv_ff[STAGES];
   assign angle     = vz_ff[STAGES];
endmodule

>>> rtl/haversine_distance_unit.sv
// ---------------------------------------------------------------------------
// haversine_distance_unit
// Great circle distance between two points with the haversine formula,
// fully pipelined, one point pair per cycle unless the output is held.
// ---------------------------------------------------------------------------
//   port       dir   word
//   req_chan   in    two points, lat/lon in 1/65536 degree
//   rsp_chan   out   distance in whole metres
//   csr_wr_*   in    sphere radius in metres
//
// One word per cycle in and out while no held result stalls the pipeline. Words pass through
// two rotation and vectoring cordic chains plus the 32-step square root.
// Synchronous reset empties the pipeline and sets the radius to 6371000 m.
// A held result stalls the whole pipeline only when the last stage is also
// full; a bubble in the stage just before the output register lets new words enter.
`include "assert_macros.svh"

module haversine_distance_unit #(
   parameter int unsigned CORDIC_STAGES = hdu_pkg::CORDIC_STAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   hdu_req_if.sink                         req_chan,
   hdu_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [hdu_pkg::RADIUS_W-1:0]    csr_wr_data
);
   import hdu_pkg::*;

   logic en_pipe;
   logic load_out;
   logic out_stall;

   logic [RADIUS_W-1:0] radius_ff;

   logic signed [UNIT_W-1:0] u_lat1, u_lat2, u_dlat, u_dlon;
   logic signed [TRIG_W-1:0] cos_lat1, cos_lat2, sin_dlat, sin_dlon;
   logic [3:0]               lane_valid;

   logic signed [63:0]      sq_dlat_ff, cc_ff, sq_dlon_ff;
   logic                    m1_valid_ff;
   logic signed [63:0]      sq_dlat2_ff;
   logic signed [AMP_W-1:0] cc_rnd_ff, sq_dlon_rnd_ff;
   logic                    m2_valid_ff;
   logic signed [63:0]      sq_dlat3_ff, cross_ff;
   logic                    m3_valid_ff;
   logic signed [63:0]      a60;
   logic [63:0]             a_rnd;
   logic [A32_W-1:0]        a32_in;
   logic [A32_W-1:0]        a32_ff;
   logic                    m4_valid_ff;

   logic [A32_W-1:0]  one_minus_a;
   logic [SQ_W-1:0]   y_rad, x_rad;
   logic [ROOT_W-1:0] y_root, x_root;
   logic              y_valid, x_valid;

   logic signed [ANG_W-1:0] vec_angle;
   logic                    vec_valid;

   logic signed [63:0]   ang2, angq;
   logic [CENT_W-1:0]    c30_in;
   logic [CENT_W-1:0]    c30_ff;
   logic                 t1_valid_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 t2_valid_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic                 rsp_valid_ff;

   // the pipeline moves unless a full last stage faces a held output word
   assign load_out       = !rsp_valid_ff || rsp_chan.ready;
   assign en_pipe        = !t2_valid_ff || load_out;
   assign out_stall      = t2_valid_ff && !load_out;
   assign req_chan.ready = en_pipe;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // latitudes doubled, differences taken as is
   always_comb begin
      u_lat1 = {req_chan.first_latitude[LAT_W-1], req_chan.first_latitude, 1'b0};
      u_lat2 = {req_chan.second_latitude[LAT_W-1], req_chan.second_latitude, 1'b0};
      u_dlat = UNIT_W'(req_chan.second_latitude) - UNIT_W'(req_chan.first_latitude);
      u_dlon = UNIT_W'(req_chan.second_longitude) - UNIT_W'(req_chan.first_longitude);
   end

   hdu_sincos #(.STAGES(CORDIC_STAGES), .COSINE(1'b1)) u_cos_lat1 (
      .clock(clock), .reset(reset), .en(en_pipe), .in_valid(req_chan.valid),
      .angle_units(u_lat1), .out_valid(lane_valid[0]), .trig_q30(cos_lat1));

   hdu_sincos #(.STAGES(CORDIC_STAGES), .COSINE(1'b1)) u_cos_lat2 (
      .clock(clock), .reset(reset), .en(en_pipe), .in_valid(req_chan.valid),
      .angle_units(u_lat2), .out_valid(lane_valid[1]), .trig_q30(cos_lat2));

   hdu_sincos #(.STAGES(CORDIC_STAGES), .COSINE(1'b0)) u_sin_dlat (
      .clock(clock), .reset(reset), .en(en_pipe), .in_valid(req_chan.valid),
      .angle_units(u_dlat), .out_valid(lane_valid[2]), .trig_q30(sin_dlat));

   hdu_sincos #(.STAGES(CORDIC_STAGES), .COSINE(1'b0)) u_sin_dlon (
      .clock(clock), .reset(reset), .en(en_pipe), .in_valid(req_chan.valid),
      .angle_units(u_dlon), .out_valid(lane_valid[3]), .trig_q30(sin_dlon));

   // haversine term a, clamped to [0,1] in Q1.32
   always_comb begin
      a60   = sq_dlat3_ff + cross_ff;
      a_rnd = (64'(a60) + (64'd1 << 27)) >> 28;
      if (a60 <= 64'sd0) begin
         a32_in = '0;
      end else if (a_rnd > 64'(A32_ONE)) begin
         a32_in = A32_ONE;
      end else begin
         a32_in = a_rnd[A32_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_pipe) begin
         sq_dlat_ff     <= sin_dlat * sin_dlat;
         cc_ff          <= cos_lat1 * cos_lat2;
         sq_dlon_ff     <= sin_dlon * sin_dlon;
         sq_dlat2_ff    <= sq_dlat_ff;
         cc_rnd_ff      <= AMP_W'(round_shift(cc_ff, 30));
         sq_dlon_rnd_ff <= AMP_W'(round_shift(sq_dlon_ff, 30));
         sq_dlat3_ff    <= sq_dlat2_ff;
         cross_ff       <= cc_rnd_ff * sq_dlon_rnd_ff;
         a32_ff         <= a32_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
      end else if (en_pipe) begin
         m1_valid_ff <= &lane_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
      end
   end

   always_comb begin
      one_minus_a = A32_ONE - a32_ff;
      y_rad       = {31'd0, a32_ff} << 31;
      x_rad       = {31'd0, one_minus_a} << 31;
   end

   hdu_isqrt u_sqrt_y (
      .clock(clock), .reset(reset), .en(en_pipe), .in_valid(m4_valid_ff),
      .radicand(y_rad), .out_valid(y_valid), .root(y_root));

   hdu_isqrt u_sqrt_x (
      .clock(clock), .reset(reset), .en(en_pipe), .in_valid(m4_valid_ff),
      .radicand(x_rad), .out_valid(x_valid), .root(x_root));

   hdu_cordic_vec #(.STAGES(CORDIC_STAGES)) u_atan2 (
      .clock(clock), .reset(reset), .en(en_pipe), .in_valid(y_valid && x_valid),
      .x_root(x_root), .y_root(y_root), .out_valid(vec_valid), .angle(vec_angle));

   // central angle in Q30, residue below zero taken as zero
   always_comb begin
      ang2   = 64'(vec_angle) <<< 1;
      angq   = to_q30(ang2);
      c30_in = angq[63] ? '0 : CENT_W'(angq);
   end

   always_ff @(posedge clock) begin
      if (en_pipe) begin
         c30_ff  <= c30_in;
         prod_ff <= PROD_W'(radius_ff) * PROD_W'(c30_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
      end else if (en_pipe) begin
         t1_valid_ff <= vec_valid;
         t2_valid_ff <= t1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         dist_ff <= DIST_W'((prod_ff + (PROD_W'(1) << 29)) >> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= t2_valid_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.distance_m = dist_ff;

   `HDU_ASSERT_NEXT(a_reset_empties_out, clock, reset, !rsp_valid_ff, "valid after reset")
   `HDU_ASSERT_IMPL(a_stall_blocks_req, clock, reset, out_stall, !req_chan.ready, "req in stall")
   `HDU_ASSERT_IMPL(a_term_clamped, clock, reset, m4_valid_ff, a32_ff <= A32_ONE, "a over one")
endmodule
